// ===== src/bbia_pkg.sv =====
// Shared types and constants of the bitmap block and inode allocator.
package bbia_pkg;

	localparam int WORD_W    = 32;
	localparam int BIT_W     = 5;
	localparam int NUM_W     = 10;
	localparam int IDX_W     = 12;
	localparam int EXT_W     = 13;
	localparam int FB_OUT_W  = 11;
	localparam int FI_OUT_W  = 9;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_ALLOC   = 2'd0;
	localparam cmd_t CMD_MARK    = 2'd1;
	localparam cmd_t CMD_RELEASE = 2'd2;
	localparam cmd_t CMD_QUERY   = 2'd3;

	localparam logic POOL_BLOCK = 1'b0;
	localparam logic POOL_INODE = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// ===== src/bbia_bitmap.sv =====
// One bitmap memory of 32-bit words with a registered read and per-row valid bits.
module bbia_bitmap #(
	parameter int WORDS = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bbia_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     rd_addr,
	input  logic [AW-1:0]     wr_addr,
	input  bbia_pkg::word_t   wr_data,
	output bbia_pkg::word_t   rd_data
);

	bbia_pkg::word_t mem [WORDS];
	bbia_pkg::word_t rdata_q;
	logic [WORDS-1:0] row_vld_q;
	logic             rvld_q;

	// A row that was never written reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_q <= row_vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

// ===== src/bbia_find.sv =====
// Priority encoder that finds the lowest clear bit of a bitmap word.
module bbia_find (
	input  bbia_pkg::word_t            used_word,
	output logic                       found,
	output logic [bbia_pkg::BIT_W-1:0] bit_idx
);

	always_comb begin
		bit_idx = '0;
		for (int i = bbia_pkg::WORD_W - 1; i >= 0; i--) begin
			if (!used_word[i]) begin
				bit_idx = bbia_pkg::BIT_W'(i);
			end
		end
	end

	assign found = ~&used_word;

endmodule

// ===== src/bitmap_block_inode_allocator_top.sv =====
// Top level of the bitmap first-fit allocator for data blocks and inodes.
//
// Requests arrive on the input channel (in_valid/in_ready) with command, pool
// and number; each request gives exactly one result on the output channel
// (out_valid/out_ready). One request is worked on at a time.
// Mark, release and query pass from the input transfer through a read of the
// bitmap word (RD), a modify and write back (UPD) and a load of the output
// register (FIN) before the result appears.
// Allocate scans the pool's bitmap memory one 32-bit word per cycle through a
// priority encoder: up to 32 words for 1024 blocks, up to 8 for 256 inodes.
// The output register holds a finished result while the receiver stalls; the
// block then waits before loading the next result, and takes a new request
// once that result has moved into the output register.
// Reset frees every entry of both pools at once (row valid bits, no clearing
// pass), sets both free counts to the pool sizes and the block search start to 0.
// Write the configuration register (cfg_we/cfg_wdata) only while idle; the block
// itself does not enforce this.
module bitmap_block_inode_allocator_top #(
	parameter int BLOCK_COUNT = 1024,
	parameter int INODE_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bbia_pkg::NUM_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bbia_pkg::cmd_t                command,
	input  logic                          pool,
	input  logic [bbia_pkg::NUM_W-1:0]    number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bbia_pkg::NUM_W-1:0]    result_number,
	output logic                          is_used,
	output logic [bbia_pkg::FB_OUT_W-1:0] free_blocks,
	output logic [bbia_pkg::FI_OUT_W-1:0] free_inodes
);

	localparam int B_WORDS = (BLOCK_COUNT + 31) / 32;
	localparam int I_WORDS = (INODE_COUNT + 31) / 32;
	localparam int B_AW    = (B_WORDS > 1) ? $clog2(B_WORDS) : 1;
	localparam int I_AW    = (I_WORDS > 1) ? $clog2(I_WORDS) : 1;
	localparam int SAW     = (B_AW > I_AW) ? B_AW : I_AW;
	localparam int CB_W    = $clog2(BLOCK_COUNT + 1);
	localparam int CI_W    = $clog2(INODE_COUNT + 1);
	localparam int B_TAIL  = BLOCK_COUNT - 32 * (B_WORDS - 1);
	localparam int I_TAIL  = INODE_COUNT - 32 * (I_WORDS - 1);

	localparam logic [SAW-1:0] B_LAST = SAW'(B_WORDS - 1);
	localparam logic [SAW-1:0] I_LAST = SAW'(I_WORDS - 1);
	localparam bbia_pkg::word_t B_TAIL_MASK = ~(32'((33'd1 << B_TAIL) - 33'd1));
	localparam bbia_pkg::word_t I_TAIL_MASK = ~(32'((33'd1 << I_TAIL) - 33'd1));
	localparam logic [CB_W-1:0] B_FULL = CB_W'(BLOCK_COUNT);
	localparam logic [CI_W-1:0] I_FULL = CI_W'(INODE_COUNT);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                          state_q;
	bbia_pkg::cmd_t                      cmd_q;
	logic                                pool_q;
	logic [bbia_pkg::IDX_W-1:0]          slot_q;
	logic                                vld_q;
	logic [SAW-1:0]                      word_q;
	logic                                first_q;
	logic                                eval_vld_s1;
	logic                                eval_first_s1;
	logic [SAW-1:0]                      eval_word_s1;
	logic [bbia_pkg::NUM_W-1:0]          res_num_q;
	logic                                res_used_q;
	logic [bbia_pkg::NUM_W-1:0]          fdb_q;
	logic [CB_W-1:0]                     fb_q;
	logic [CI_W-1:0]                     fi_q;
	logic                                out_valid_q;
	logic [bbia_pkg::NUM_W-1:0]          out_num_q;
	logic                                out_used_q;
	logic [bbia_pkg::FB_OUT_W-1:0]       out_fb_q;
	logic [bbia_pkg::FI_OUT_W-1:0]       out_fi_q;

	logic [bbia_pkg::EXT_W-1:0]          num_ext;
	logic [bbia_pkg::EXT_W-1:0]          fdb_ext;
	logic                                blk_ok;
	logic                                ino_ok;
	logic                                fdb_ok;
	logic [bbia_pkg::NUM_W-1:0]          slot_in;
	logic [bbia_pkg::EXT_W-1:0]          fb_ext;
	logic [bbia_pkg::EXT_W-1:0]          fi_ext;

	bbia_pkg::word_t                     rdata;
	bbia_pkg::word_t                     blk_rdata;
	bbia_pkg::word_t                     ino_rdata;
	bbia_pkg::word_t                     scan_word;
	bbia_pkg::word_t                     bit_mask;
	bbia_pkg::word_t                     wr_data;
	logic [SAW-1:0]                      rd_addr;
	logic [SAW-1:0]                      wr_addr;
	logic                                rd_en;
	logic                                wr_en;
	logic                                found;
	logic [bbia_pkg::BIT_W-1:0]          found_bit;
	logic                                scan_hit;
	logic                                scan_end;
	logic                                cnt_dec;
	logic                                cnt_inc;
	logic [bbia_pkg::IDX_W-1:0]          hit_idx;
	logic                                out_free;
	bbia_pkg::mem_ctl_t                  blk_ctl;
	bbia_pkg::mem_ctl_t                  ino_ctl;

	assign num_ext = bbia_pkg::EXT_W'(number);
	assign fdb_ext = bbia_pkg::EXT_W'(fdb_q);
	assign blk_ok  = num_ext < bbia_pkg::EXT_W'(BLOCK_COUNT);
	assign ino_ok  = (number != '0) && (num_ext <= bbia_pkg::EXT_W'(INODE_COUNT));
	assign fdb_ok  = fdb_ext < bbia_pkg::EXT_W'(BLOCK_COUNT);
	assign slot_in = (pool == bbia_pkg::POOL_INODE) ? number - 1'b1 : number;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign rdata = (pool_q == bbia_pkg::POOL_INODE) ? ino_rdata : blk_rdata;
	assign bit_mask = bbia_pkg::word_t'(1) << slot_q[bbia_pkg::BIT_W-1:0];

	// Bits below the search start and past the pool end count as used.
	always_comb begin
		scan_word = rdata;
		if (pool_q == bbia_pkg::POOL_BLOCK) begin
			if (eval_first_s1) begin
				scan_word = scan_word
					| 32'((33'd1 << fdb_q[bbia_pkg::BIT_W-1:0]) - 33'd1);
			end
			if (eval_word_s1 == B_LAST) begin
				scan_word = scan_word | B_TAIL_MASK;
			end
		end else begin
			if (eval_word_s1 == I_LAST) begin
				scan_word = scan_word | I_TAIL_MASK;
			end
		end
	end

	bbia_find u_find (
		.used_word (scan_word),
		.found     (found),
		.bit_idx   (found_bit)
	);

	assign hit_idx  = bbia_pkg::IDX_W'({eval_word_s1, found_bit});
	assign scan_hit = eval_vld_s1 && found;
	assign scan_end = eval_vld_s1 && !found
		&& (eval_word_s1 == ((pool_q == bbia_pkg::POOL_INODE) ? I_LAST : B_LAST));

	always_comb begin
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		cnt_dec = 1'b0;
		cnt_inc = 1'b0;
		rd_addr = slot_q[bbia_pkg::BIT_W +: SAW];
		wr_addr = slot_q[bbia_pkg::BIT_W +: SAW];
		wr_data = rdata | bit_mask;
		case (state_q)
			ST_RD: begin
				rd_en = vld_q;
			end
			ST_UPD: begin
				case (cmd_q)
					bbia_pkg::CMD_MARK: begin
						wr_en   = vld_q;
						cnt_dec = vld_q;
					end
					bbia_pkg::CMD_RELEASE: begin
						wr_en   = vld_q;
						cnt_inc = vld_q;
						wr_data = rdata & ~bit_mask;
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				rd_addr = word_q;
				wr_addr = eval_word_s1;
				wr_data = rdata | (bbia_pkg::word_t'(1) << found_bit);
				if (scan_hit) begin
					wr_en   = 1'b1;
					cnt_dec = 1'b1;
				end else if (!scan_end) begin
					rd_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign blk_ctl.rd_en = rd_en && (pool_q == bbia_pkg::POOL_BLOCK);
	assign blk_ctl.wr_en = wr_en && (pool_q == bbia_pkg::POOL_BLOCK);
	assign ino_ctl.rd_en = rd_en && (pool_q == bbia_pkg::POOL_INODE);
	assign ino_ctl.wr_en = wr_en && (pool_q == bbia_pkg::POOL_INODE);

	bbia_bitmap #(
		.WORDS (B_WORDS),
		.AW    (B_AW)
	) u_blk_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (blk_ctl),
		.rd_addr (rd_addr[B_AW-1:0]),
		.wr_addr (wr_addr[B_AW-1:0]),
		.wr_data (wr_data),
		.rd_data (blk_rdata)
	);

	bbia_bitmap #(
		.WORDS (I_WORDS),
		.AW    (I_AW)
	) u_ino_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ino_ctl),
		.rd_addr (rd_addr[I_AW-1:0]),
		.wr_addr (wr_addr[I_AW-1:0]),
		.wr_data (wr_data),
		.rd_data (ino_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fdb_q         <= '0;
			fb_q          <= B_FULL;
			fi_q          <= I_FULL;
			eval_vld_s1   <= 1'b0;
			eval_first_s1 <= 1'b0;
			first_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				fdb_q <= cfg_wdata;
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_dec) begin
				if (pool_q == bbia_pkg::POOL_INODE) begin
					fi_q <= (fi_q == '0) ? fi_q : fi_q - 1'b1;
				end else begin
					fb_q <= (fb_q == '0) ? fb_q : fb_q - 1'b1;
				end
			end
			if (cnt_inc) begin
				if (pool_q == bbia_pkg::POOL_INODE) begin
					fi_q <= (fi_q >= I_FULL) ? I_FULL : fi_q + 1'b1;
				end else begin
					fb_q <= (fb_q >= B_FULL) ? B_FULL : fb_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						eval_vld_s1 <= 1'b0;
						first_q     <= 1'b1;
						if (command != bbia_pkg::CMD_ALLOC) begin
							state_q <= ST_RD;
						end else if (pool == bbia_pkg::POOL_BLOCK && !fdb_ok) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					if (scan_hit || scan_end) begin
						state_q <= ST_FIN;
					end else begin
						eval_vld_s1   <= 1'b1;
						eval_first_s1 <= first_q;
						first_q       <= 1'b0;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign fb_ext = bbia_pkg::EXT_W'(fb_q);
	assign fi_ext = bbia_pkg::EXT_W'(fi_q);

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_q      <= command;
					pool_q     <= pool;
					slot_q     <= bbia_pkg::IDX_W'(slot_in);
					vld_q      <= (pool == bbia_pkg::POOL_INODE) ? ino_ok : blk_ok;
					res_num_q  <= '0;
					res_used_q <= 1'b0;
					word_q     <= (pool == bbia_pkg::POOL_INODE)
						? '0 : fdb_ext[bbia_pkg::BIT_W +: SAW];
				end
			end
			ST_UPD: begin
				if (cmd_q == bbia_pkg::CMD_QUERY) begin
					res_used_q <= vld_q && rdata[slot_q[bbia_pkg::BIT_W-1:0]];
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					res_num_q <= (pool_q == bbia_pkg::POOL_INODE)
						? hit_idx[bbia_pkg::NUM_W-1:0] + 1'b1
						: hit_idx[bbia_pkg::NUM_W-1:0];
				end else if (!scan_end) begin
					eval_word_s1 <= word_q;
					word_q       <= word_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_num_q  <= res_num_q;
					out_used_q <= res_used_q;
					out_fb_q   <= fb_ext[bbia_pkg::FB_OUT_W-1:0];
					out_fi_q   <= fi_ext[bbia_pkg::FI_OUT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign result_number = out_num_q;
	assign is_used       = out_used_q;
	assign free_blocks   = out_fb_q;
	assign free_inodes   = out_fi_q;

endmodule

// ===== src/bbia_check.sv =====
// Port checker for the allocator top level and its bind statement.
module bbia_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bbia_pkg::NUM_W-1:0]    result_number,
	input logic                          is_used,
	input logic [bbia_pkg::FB_OUT_W-1:0] free_blocks,
	input logic [bbia_pkg::FI_OUT_W-1:0] free_inodes
);

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_number)
			&& $stable(is_used) && $stable(free_blocks) && $stable(free_inodes))
		else $error("stalled result changed");

	// Only one request is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	// A query never reports an allocated number.
	a_query_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_used |-> result_number == '0)
		else $error("query answer carries an allocated number");

	// A new result only appears after work that held off the input.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a request in work");

endmodule

bind bitmap_block_inode_allocator_top bbia_check u_check (.*);
